// ===== rtl/core/pcid_pkg.sv =====
package pcid_pkg;

    // Default geometry of the id space.
    localparam int MAX_CORES_DEF    = 4;
    localparam int IDS_PER_CORE_DEF = 64;
    localparam int PUBLIC_IDS_DEF   = 64;

    // Fixed field widths of the channels.
    localparam int OP_W        = 2;
    localparam int CORE_ID_W   = 3;
    localparam int SOCK_TYPE_W = 2;
    localparam int SOCK_ID_W   = 9;
    localparam int STATUS_W    = 2;
    localparam int REPORT_W    = 7;
    localparam int ACTIVE_W    = 3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;
    localparam int REPORT_MAX = (1 << REPORT_W) - 1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_POOL_EMPTY   = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_INACTIVE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [CORE_ID_W-1:0]   core_id;
        logic [SOCK_TYPE_W-1:0] sock_type;
        logic [SOCK_ID_W-1:0]   sock_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SOCK_ID_W-1:0] granted_id;
        logic [REPORT_W-1:0]  pool_free_count;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;  // take the request beat and launch the memory reads
        logic sweep;    // write one entry of the link and kind memories
        logic commit;   // update the pools and load the result register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic req_is_init;
        logic sweep_last;
    } sts_t;

endpackage

// ===== rtl/core/per_core_id_pool_allocator.sv =====
// Identifier pool allocator with one FIFO free list per active core and one
// public list. Requests arrive as beats on the req channel (operation, core,
// type, id) and each request produces exactly one beat on the rsp channel
// (status, granted id, free count of the pool touched). The single
// configuration register, active_cores, is written through the cfg channel,
// which is always ready and should only be used while no request is in
// flight.
// In alloc and free the accept cycle reads the link and type memories, and
// the exec state then updates the pool and loads the result register once
// the output is free; a new request is taken only after that load.
// Init rebuilds every list by walking all ids through the link and type
// memories, one id per cycle.
// After reset all pools are empty and a clearing pass over all ids zeroes
// the type memory; req_ready stays low until it ends. A stalled receiver
// holds the result register; one further request may be accepted and waits
// until the result is taken.
module per_core_id_pool_allocator #(
    parameter int MAX_CORES    = pcid_pkg::MAX_CORES_DEF,
    parameter int IDS_PER_CORE = pcid_pkg::IDS_PER_CORE_DEF,
    parameter int PUBLIC_IDS   = pcid_pkg::PUBLIC_IDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  pcid_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output pcid_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pcid_pkg::ACTIVE_W-1:0]   cfg_data
);

    pcid_pkg::cmd_t cmd;
    pcid_pkg::sts_t sts;

    // The register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencing of the accept, sweep and commit steps.
    pcid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Pool descriptors, link and type memories and the result register.
    pcid_datapath #(
        .MAX_CORES    (MAX_CORES),
        .IDS_PER_CORE (IDS_PER_CORE),
        .PUBLIC_IDS   (PUBLIC_IDS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/core/pcid_ctrl.sv =====
module pcid_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  pcid_pkg::sts_t   sts,
    output pcid_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.req_is_init ? S_SWEEP : S_EXEC;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/core/pcid_datapath.sv =====
module pcid_datapath #(
    parameter int MAX_CORES    = pcid_pkg::MAX_CORES_DEF,
    parameter int IDS_PER_CORE = pcid_pkg::IDS_PER_CORE_DEF,
    parameter int PUBLIC_IDS   = pcid_pkg::PUBLIC_IDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pcid_pkg::req_t                  req,
    input  logic                            cfg_we,
    input  logic [pcid_pkg::ACTIVE_W-1:0]   cfg_data,
    input  pcid_pkg::cmd_t                  cmd,
    output pcid_pkg::sts_t                  sts,
    output pcid_pkg::rsp_t                  rsp
);

    localparam int TOTAL_IDS = MAX_CORES * IDS_PER_CORE + PUBLIC_IDS;
    localparam int NPOOLS    = MAX_CORES + 1;
    localparam int ID_W      = $clog2(TOTAL_IDS);
    localparam int CNT_W     = $clog2(TOTAL_IDS + 1);
    localparam int POOL_W    = $clog2(NPOOLS);
    localparam int OUT_ID_W  = pcid_pkg::SOCK_ID_W;
    localparam int REP_W     = pcid_pkg::REPORT_W;
    localparam int TYPE_W    = pcid_pkg::SOCK_TYPE_W;
    localparam int OP_W      = pcid_pkg::OP_W;
    localparam logic [POOL_W-1:0] PUB_POOL = POOL_W'(MAX_CORES);

    // Configuration and pool descriptors.
    logic [pcid_pkg::ACTIVE_W-1:0] active_reg;
    logic [ID_W-1:0]  head_reg  [NPOOLS];
    logic [ID_W-1:0]  tail_reg  [NPOOLS];
    logic [CNT_W-1:0] count_reg [NPOOLS];
    logic [ID_W-1:0]  sweep_reg;

    // Id memories.
    logic [ID_W-1:0]   link_mem [TOTAL_IDS];
    logic [TYPE_W-1:0] kind_mem [TOTAL_IDS];
    logic [ID_W-1:0]   link_rd_reg;
    logic [TYPE_W-1:0] kind_rd_reg;

    // Request captured at accept time.
    logic [OP_W-1:0]         op_reg;
    logic [TYPE_W-1:0]       type_reg;
    logic [OUT_ID_W-1:0]     id_reg;
    logic                    inactive_reg;
    logic [POOL_W-1:0]       pool_reg;
    logic [ID_W-1:0]         head_q_reg;
    logic [ID_W-1:0]         tail_q_reg;
    logic [CNT_W-1:0]        count_q_reg;

    logic [POOL_W-1:0] n_eff;
    logic              req_inactive;
    logic [POOL_W-1:0] pool_sel;
    logic [ID_W-1:0]   free_id;
    logic              alloc_ok;
    logic              free_ok;
    logic              id_bad;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  report;
    logic              kind_we;
    logic [ID_W-1:0]   kind_wa;
    logic [TYPE_W-1:0] kind_wd;
    pcid_pkg::rsp_t    rsp_next;
    logic              init_pub_wide;

    // Register values above the core count act as the core count.
    assign n_eff = (32'(active_reg) > MAX_CORES) ? PUB_POOL : POOL_W'(active_reg);
    assign req_inactive = 32'(req.core_id) >= 32'(n_eff);
    assign pool_sel     = req_inactive ? PUB_POOL : POOL_W'(req.core_id);

    assign sts.req_is_init = (req.operation == pcid_pkg::OP_INIT);
    assign sts.sweep_last  = (32'(sweep_reg) == TOTAL_IDS - 1);

    assign free_id   = ID_W'(id_reg);
    assign id_bad    = (32'(id_reg) >= TOTAL_IDS) || (kind_rd_reg == '0);
    assign alloc_ok  = (op_reg == pcid_pkg::OP_ALLOC) && (count_q_reg != '0);
    assign free_ok   = (op_reg == pcid_pkg::OP_FREE) && !inactive_reg && !id_bad;
    assign count_dec = count_q_reg - CNT_W'(1);
    assign count_inc = count_q_reg + CNT_W'(1);
    assign init_pub_wide = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= pcid_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_reg <= sts.sweep_last ? '0 : sweep_reg + ID_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= req.operation;
            type_reg     <= req.sock_type;
            id_reg       <= req.sock_id;
            inactive_reg <= req_inactive;
            pool_reg     <= pool_sel;
            head_q_reg   <= head_reg[pool_sel];
            tail_q_reg   <= tail_reg[pool_sel];
            count_q_reg  <= count_reg[pool_sel];
        end
    end

    // Link memory: the sweep chains every id to the next one; an append
    // links the old tail to the new id.
    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            link_mem[sweep_reg] <= sweep_reg + ID_W'(1);
        end
        else if (cmd.commit && free_ok && (count_q_reg != '0))
        begin
            link_mem[tail_q_reg] <= free_id;
        end
        if (cmd.capture)
        begin
            link_rd_reg <= link_mem[head_reg[pool_sel]];
        end
    end

    always_comb
    begin
        kind_we = 1'b0;
        kind_wa = sweep_reg;
        kind_wd = '0;
        if (cmd.sweep)
        begin
            kind_we = 1'b1;
        end
        else if (cmd.commit && alloc_ok)
        begin
            kind_we = 1'b1;
            kind_wa = head_q_reg;
            kind_wd = type_reg;
        end
        else if (cmd.commit && free_ok)
        begin
            kind_we = 1'b1;
            kind_wa = free_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kind_we)
        begin
            kind_mem[kind_wa] <= kind_wd;
        end
        if (cmd.capture)
        begin
            kind_rd_reg <= kind_mem[ID_W'(req.sock_id)];
        end
    end

    // Pool descriptors.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NPOOLS; p++)
            begin
                head_reg[p]  <= '0;
                tail_reg[p]  <= '0;
                count_reg[p] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            case (op_reg)
                pcid_pkg::OP_INIT:
                begin
                    for (int p = 0; p < MAX_CORES; p++)
                    begin
                        if (p < 32'(n_eff))
                        begin
                            head_reg[p]  <= ID_W'(p * IDS_PER_CORE);
                            tail_reg[p]  <= ID_W'((p + 1) * IDS_PER_CORE - 1);
                            count_reg[p] <= CNT_W'(IDS_PER_CORE);
                        end
                        else
                        begin
                            head_reg[p]  <= '0;
                            tail_reg[p]  <= '0;
                            count_reg[p] <= '0;
                        end
                    end
                    head_reg[PUB_POOL]  <= ID_W'(MAX_CORES * IDS_PER_CORE);
                    tail_reg[PUB_POOL]  <= ID_W'(TOTAL_IDS - 1);
                    count_reg[PUB_POOL] <= CNT_W'(PUBLIC_IDS);
                end
                pcid_pkg::OP_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        count_reg[pool_reg] <= count_dec;
                        if (count_dec != '0)
                        begin
                            head_reg[pool_reg] <= link_rd_reg;
                        end
                    end
                end
                pcid_pkg::OP_FREE:
                begin
                    if (free_ok)
                    begin
                        count_reg[pool_reg] <= count_inc;
                        tail_reg[pool_reg]  <= free_id;
                        if (count_q_reg == '0)
                        begin
                            head_reg[pool_reg] <= free_id;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result.
    always_comb
    begin
        rsp_next = '0;
        report   = '0;
        case (op_reg)
            pcid_pkg::OP_INIT:
            begin
                report = CNT_W'(PUBLIC_IDS);
            end
            pcid_pkg::OP_ALLOC:
            begin
                if (alloc_ok)
                begin
                    rsp_next.granted_id = OUT_ID_W'(head_q_reg);
                    report              = count_dec;
                end
                else
                begin
                    rsp_next.status = pcid_pkg::ST_POOL_EMPTY;
                end
            end
            pcid_pkg::OP_FREE:
            begin
                if (inactive_reg)
                begin
                    rsp_next.status = pcid_pkg::ST_INACTIVE;
                end
                else if (id_bad)
                begin
                    rsp_next.status = pcid_pkg::ST_ALREADY_FREE;
                    report          = count_q_reg;
                end
                else
                begin
                    report = count_inc;
                end
            end
            default:
            begin
            end
        endcase
        if (init_pub_wide && (32'(report) > pcid_pkg::REPORT_MAX))
        begin
            rsp_next.pool_free_count = REP_W'(pcid_pkg::REPORT_MAX);
        end
        else
        begin
            rsp_next.pool_free_count = REP_W'(report);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp <= rsp_next;
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench for the identifier pool allocator.
//
// Requests go in as beats on the req channel from a backlog queue that the
// stimulus process fills. Each accepted beat runs through a predictor that
// keeps its own copy of the free lists, the link memory, the type memory and
// the active_cores register. The predicted response beat goes into a queue,
// and the monitor compares every response beat, field by field, with the
// oldest entry of that queue.
module tb_top;

    import pcid_pkg::*;

    // Geometry of the instance under test.
    localparam int MAX_CORES    = MAX_CORES_DEF;
    localparam int IDS_PER_CORE = IDS_PER_CORE_DEF;
    localparam int PUBLIC_IDS   = PUBLIC_IDS_DEF;
    localparam int TOTAL_IDS    = MAX_CORES * IDS_PER_CORE + PUBLIC_IDS;
    localparam int PUB_POOL     = MAX_CORES;

    // The operation code that the block decodes to nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_GOAL   = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int CLOSE_WAIT  = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                req_valid = 1'b0;
    logic                req_ready;
    req_t                req_beat = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp_beat;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ACTIVE_W-1:0] cfg_data = '0;

    per_core_id_pool_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Predictor state. The lists are FIFOs threaded through next_link, with
    // pool_first as the head, pool_last as the tail and pool_fill as the
    // number of entries. Index PUB_POOL is the public list.
    int unsigned cores_cfg = ACTIVE_RESET;
    int unsigned pool_first [0:MAX_CORES];
    int unsigned pool_last  [0:MAX_CORES];
    int unsigned pool_fill  [0:MAX_CORES];
    logic [SOCK_ID_W-1:0]   next_link [0:TOTAL_IDS-1];
    logic [SOCK_TYPE_W-1:0] id_kind   [0:TOTAL_IDS-1];

    // Ids handed out with a nonzero type, so that the stimulus can free ids
    // that are really in use.
    int unsigned live_ids [$];

    req_t req_backlog  [$];
    rsp_t awaited_rsps [$];

    int  items_queued = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  jitter_on = 1'b1;

    int   send_gap = 0;
    int   hold_off = 0;
    logic next_valid;
    req_t next_beat;
    rsp_t want;

    initial
    begin
        for (int p = 0; p <= MAX_CORES; p++)
        begin
            pool_first[p] = 0;
            pool_last[p]  = 0;
            pool_fill[p]  = 0;
        end
        for (int i = 0; i < TOTAL_IDS; i++)
        begin
            next_link[i] = '0;
            id_kind[i]   = '0;
        end
    end

    function automatic logic [REPORT_W-1:0] report_count(input int unsigned fill);
        return (fill > REPORT_MAX) ? REPORT_MAX[REPORT_W-1:0] : fill[REPORT_W-1:0];
    endfunction

    function automatic void link_onto_pool(input int unsigned pool, input int unsigned id);
        if (pool_fill[pool] == 0)
            pool_first[pool] = id;
        else
            next_link[pool_last[pool]] = SOCK_ID_W'(id);
        pool_last[pool] = id;
        pool_fill[pool]++;
    endfunction

    // Applies one request to the predictor state and returns the response
    // beat that the block must produce for it.
    function automatic rsp_t predict_pool_result(input req_t beat);
        rsp_t        res;
        int unsigned n;
        int unsigned pool;
        int unsigned got;
        res = '0;
        n = (cores_cfg > MAX_CORES) ? MAX_CORES : cores_cfg;
        case (beat.operation)
            OP_INIT:
            begin
                // Only active cores get their block of ids; the public list
                // always gets the ids that follow all core ids.
                for (int p = 0; p <= MAX_CORES; p++)
                begin
                    pool_first[p] = 0;
                    pool_last[p]  = 0;
                    pool_fill[p]  = 0;
                end
                for (int i = 0; i < TOTAL_IDS; i++)
                    id_kind[i] = '0;
                for (int c = 0; c < n; c++)
                    for (int i = c * IDS_PER_CORE; i < (c + 1) * IDS_PER_CORE; i++)
                        link_onto_pool(c, i);
                for (int i = MAX_CORES * IDS_PER_CORE; i < TOTAL_IDS; i++)
                    link_onto_pool(PUB_POOL, i);
                live_ids.delete();
                res.pool_free_count = report_count(pool_fill[PUB_POOL]);
            end
            OP_ALLOC:
            begin
                pool = (beat.core_id >= n) ? PUB_POOL : beat.core_id;
                if (pool_fill[pool] == 0)
                    res.status = ST_POOL_EMPTY;
                else
                begin
                    got = pool_first[pool];
                    pool_fill[pool]--;
                    if (pool_fill[pool] != 0)
                        pool_first[pool] = next_link[got];
                    // A zero type leaves the id marked unused, so it cannot be
                    // freed again before the next init.
                    id_kind[got] = beat.sock_type;
                    res.granted_id = SOCK_ID_W'(got);
                    if (beat.sock_type != 0)
                        live_ids.push_back(got);
                end
                res.pool_free_count = report_count(pool_fill[pool]);
            end
            OP_FREE:
            begin
                // An inactive core is checked before the id itself.
                if (beat.core_id >= n)
                    res.status = ST_INACTIVE;
                else if (beat.sock_id >= TOTAL_IDS || id_kind[beat.sock_id] == 0)
                begin
                    res.status = ST_ALREADY_FREE;
                    res.pool_free_count = report_count(pool_fill[beat.core_id]);
                end
                else
                begin
                    // Public ids join the named core's list like any other.
                    id_kind[beat.sock_id] = '0;
                    link_onto_pool(beat.core_id, beat.sock_id);
                    res.pool_free_count = report_count(pool_fill[beat.core_id]);
                end
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(99);
        if (!jitter_on || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 15);
    endfunction

    // Request driver. An accepted beat is predicted at the edge that takes
    // it; valid then drops only if no next beat is due at once, so a
    // back-to-back stream never lowers and raises valid in one step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_beat  <= '0;
            send_gap = 0;
        end
        else
        begin
            next_valid = req_valid;
            next_beat  = req_beat;
            if (req_valid && req_ready)
            begin
                awaited_rsps.push_back(predict_pool_result(req_beat));
                next_valid = 1'b0;
                send_gap = draw_gap();
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (req_backlog.size() != 0)
                begin
                    next_beat  = req_backlog.pop_front();
                    next_valid = 1'b1;
                end
            end
            req_valid <= next_valid;
            req_beat  <= next_beat;
        end
    end

    task automatic compare_field(input string field, input logic [SOCK_ID_W-1:0] expected,
                                 input logic [SOCK_ID_W-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            mismatches++;
        end
    endtask

    // Response monitor. Stalls start after a beat or at random while idle,
    // so they land both on waiting results and on results still in flight.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_off = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    $error("response beat with nothing expected: status %0d id %0d count %0d",
                           rsp_beat.status, rsp_beat.granted_id, rsp_beat.pool_free_count);
                    mismatches++;
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    compare_field("status", want.status, rsp_beat.status);
                    compare_field("granted_id", want.granted_id, rsp_beat.granted_id);
                    compare_field("pool_free_count", want.pool_free_count,
                                  rsp_beat.pool_free_count);
                end
                hold_off = draw_gap();
            end
            else if (hold_off > 0)
                hold_off--;
            else if ($urandom_range(7) == 0)
                hold_off = draw_gap();
            rsp_ready <= (hold_off == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** per_core_id_pool_allocator: FAILED **");
            $finish;
        end
    end

    // The backlog is kept short so that frees are drawn from ids that were
    // handed out only a few beats earlier.
    task automatic queue_req(input logic [OP_W-1:0] op, input int core, input int kind,
                             input int id);
        req_t beat;
        while (req_backlog.size() >= 4)
            @(negedge clk);
        beat.operation = op;
        beat.core_id   = CORE_ID_W'(core);
        beat.sock_type = SOCK_TYPE_W'(kind);
        beat.sock_id   = SOCK_ID_W'(id);
        req_backlog.push_back(beat);
        if (op != OP_UNUSED)
            items_queued++;
    endtask

    // Returns once every queued beat has been sent and answered.
    task automatic settle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || awaited_rsps.size() != 0);
    endtask

    task automatic write_active_cores(input int value);
        settle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ACTIVE_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cores_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    // Mostly numbers below MAX_CORES, sometimes numbers that always fall to the public pool.
    function automatic int pick_core();
        return ($urandom_range(4) != 0) ? $urandom_range(MAX_CORES - 1)
                                        : $urandom_range(7, MAX_CORES);
    endfunction

    initial
    begin
        int phase_cfg;
        int funnel_core;
        int hot_core;
        int alloc_cut;
        int roll;
        int core;
        int kind;
        int id;
        int slot;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset value of active_cores. Nothing has been
        // built yet, so the first alloc finds an empty pool and the first
        // free finds an unused id.
        queue_req(OP_ALLOC, 0, 1, 0);
        queue_req(OP_FREE, 0, 1, 5);
        queue_req(OP_UNUSED, 7, 3, 511);
        queue_req(OP_INIT, 0, 0, 0);
        queue_req(OP_ALLOC, 0, 3, 0);
        queue_req(OP_ALLOC, 3, 1, 0);
        queue_req(OP_ALLOC, 7, 2, 0);
        // Zero type: the id leaves the public list but stays marked unused.
        queue_req(OP_ALLOC, 4, 0, 0);
        queue_req(OP_FREE, 0, 1, 0);
        queue_req(OP_FREE, 0, 1, 0);
        queue_req(OP_FREE, 1, 1, 257);
        // A public id freed to a core lands on that core's list.
        queue_req(OP_FREE, 2, 2, 256);
        queue_req(OP_FREE, 4, 1, 192);
        queue_req(OP_FREE, 3, 1, 511);
        queue_req(OP_FREE, 3, 1, TOTAL_IDS);
        queue_req(OP_FREE, 3, 3, 192);

        // One active core: core 1 allocates from the public list and its
        // frees are rejected.
        write_active_cores(1);
        queue_req(OP_INIT, 5, 2, 300);
        queue_req(OP_ALLOC, 1, 2, 0);
        queue_req(OP_FREE, 1, 2, 256);
        queue_req(OP_FREE, 0, 2, 256);

        // No active core at all.
        write_active_cores(0);
        queue_req(OP_ALLOC, 0, 1, 0);
        queue_req(OP_FREE, 0, 1, 257);
        queue_req(OP_INIT, 0, 1, 0);

        // Values above the core count act as the full count.
        write_active_cores(7);
        queue_req(OP_INIT, 2, 3, 17);
        queue_req(OP_ALLOC, 6, 3, 0);
        queue_req(OP_FREE, 3, 1, 0);

        // Random phases. Each one picks a register value, usually starts with
        // an init, then mixes allocs with frees, mostly of ids in use. A funnel
        // phase sends most frees to one core so that its count passes the
        // reporting limit; a hog phase drains one pool until it runs empty.
        while (items_queued < ITEM_GOAL)
        begin
            case ($urandom_range(7))
                0: phase_cfg = 0;
                1: phase_cfg = 1;
                2: phase_cfg = 7;
                3, 4: phase_cfg = MAX_CORES;
                default: phase_cfg = $urandom_range(3, 2);
            endcase
            write_active_cores(phase_cfg);
            jitter_on = ($urandom_range(3) != 0);
            funnel_core = -1;
            hot_core = -1;
            case ($urandom_range(3))
                0: funnel_core = $urandom_range(MAX_CORES - 1);
                1: hot_core = $urandom_range(7);
                default: ;
            endcase
            alloc_cut = (hot_core >= 0) ? 62 : 50;
            if ($urandom_range(4) != 0)
                queue_req(OP_INIT, pick_core(), $urandom_range(3), $urandom_range(511));

            repeat ($urandom_range(220, 60))
            begin
                roll = $urandom_range(99);
                core = pick_core();
                kind = ($urandom_range(15) == 0) ? 0 : $urandom_range(3, 1);
                if (roll < 2)
                    queue_req(OP_INIT, core, kind, $urandom_range(511));
                else if (roll < 3)
                    queue_req(OP_UNUSED, core, kind, $urandom_range(511));
                else if (roll < alloc_cut)
                begin
                    if (hot_core >= 0 && $urandom_range(4) != 0)
                        core = hot_core;
                    else if (core == funnel_core)
                        core = $urandom_range(7, MAX_CORES);
                    queue_req(OP_ALLOC, core, kind, $urandom_range(511));
                end
                else if (roll < 90 && live_ids.size() != 0)
                begin
                    slot = $urandom_range(live_ids.size() - 1);
                    id = live_ids[slot];
                    live_ids[slot] = live_ids[$];
                    void'(live_ids.pop_back());
                    if (funnel_core >= 0 && $urandom_range(5) != 0)
                        core = funnel_core;
                    queue_req(OP_FREE, core, kind, id);
                end
                else
                    queue_req(OP_FREE, core, kind,
                              ($urandom_range(3) == 0) ? $urandom_range(511)
                                                       : $urandom_range(TOTAL_IDS - 1));
            end
        end

        settle();
        repeat (CLOSE_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("** per_core_id_pool_allocator: PASSED **");
        else
            $display("** per_core_id_pool_allocator: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pcid_pkg.sv
rtl/core/pcid_ctrl.sv
rtl/core/pcid_datapath.sv
rtl/core/per_core_id_pool_allocator.sv
test/tb_top.sv
